// ----- hw/rtl/strint_pkg.sv -----
// types and constants shared by the string to integer parser modules
package strint_pkg;

    // parse mode register values
    typedef enum logic [1:0] {
        MODE_U64   = 2'd0,
        MODE_S64   = 2'd1,
        MODE_OCT32 = 2'd2,
        MODE_S32   = 2'd3
    } strint_mode_t;

    // parse phases
    typedef enum logic [2:0] {
        PH_INIT = 3'd0,
        PH_ZERO = 3'd1,
        PH_HEX  = 3'd2,
        PH_OCT  = 3'd3,
        PH_DEC  = 3'd4,
        PH_WS   = 3'd5
    } strint_phase_t;

    // result status codes
    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_NODIG    = 4'd1,
        ST_NEG      = 4'd2,
        ST_BADFIRST = 4'd3,
        ST_DBLZERO  = 4'd4,
        ST_BADOCT   = 4'd5,
        ST_TRAIL    = 4'd6,
        ST_BADDIG   = 4'd7,
        ST_OVF64    = 4'd8,
        ST_BIG64    = 4'd9,
        ST_BIGINT   = 4'd10,
        ST_NEGINT   = 4'd11
    } strint_status_t;

    localparam logic [63:0] INT_MAX_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] INT_MAX_NEG = 64'h0000_0000_8000_0000;

    // one classified character travelling from front to back
    typedef struct packed {
        logic       term;
        logic       ws;
        logic       zero;
        logic       minus;
        logic       ex;
        logic       dec_ok;
        logic       oct_ok;
        logic       hex_ok;
        logic [3:0] digit;
    } strint_item_t;

endpackage

// ----- hw/rtl/strint_front.sv -----
// front end: accepts characters and classifies them for the back end
module strint_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_char_code,
    output logic                  push_valid,
    input  logic                  push_ready,
    output strint_pkg::strint_item_t push_item
);
    import strint_pkg::*;

    logic is_num;
    logic is_lower;
    logic is_upper;

    // handshake straight onto the queue
    assign push_valid = s_valid;
    assign s_ready    = push_ready;

    // character classes
    always_comb begin
        is_num   = (s_char_code >= 8'h30) && (s_char_code <= 8'h39);
        is_lower = (s_char_code >= 8'h61) && (s_char_code <= 8'h66);
        is_upper = (s_char_code >= 8'h41) && (s_char_code <= 8'h46);

        push_item.term   = (s_char_code == 8'h00);
        push_item.ws     = (s_char_code == 8'h20) ||
                           ((s_char_code >= 8'h09) && (s_char_code <= 8'h0D));
        push_item.zero   = (s_char_code == 8'h30);
        push_item.minus  = (s_char_code == 8'h2D);
        push_item.ex     = (s_char_code == 8'h78);
        push_item.dec_ok = is_num;
        push_item.oct_ok = (s_char_code >= 8'h30) && (s_char_code <= 8'h37);
        push_item.hex_ok = is_num || is_lower || is_upper;
        // letters a-f and A-F have low nibbles 1 to 6
        if (is_num) begin
            push_item.digit = s_char_code[3:0];
        end else begin
            push_item.digit = s_char_code[3:0] + 4'd9;
        end
    end

endmodule

// ----- hw/rtl/strint_queue.sv -----
// two entry queue between front and back end
module strint_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push_valid,
    output logic                     push_ready,
    input  strint_pkg::strint_item_t push_item,
    output logic                     pop_valid,
    input  logic                     pop_ready,
    output strint_pkg::strint_item_t pop_item
);
    import strint_pkg::*;

    strint_item_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push;
    logic         do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/strint_back.sv -----
// back end: parse state machine, accumulator and result register
module strint_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  strint_pkg::strint_mode_t mode,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  strint_pkg::strint_item_t pop_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [63:0]              m_parsed_value,
    output logic [3:0]               m_status_code
);
    import strint_pkg::*;

    strint_phase_t  phase_reg, phase_next;
    logic [63:0]    acc_reg, acc_next;
    logic           neg_reg, neg_next;
    strint_status_t err_reg, err_next;
    logic           m_valid_reg, m_valid_next;
    logic [63:0]    value_reg, value_next;
    strint_status_t status_reg, status_next;

    logic           out_free;
    logic           take;
    logic           allow_neg;
    logic           force_oct;
    logic           dig_ok;
    logic [67:0]    scaled;
    logic [67:0]    stepped;
    logic [63:0]    fin_value;
    strint_status_t fin_status;

    assign out_free  = !m_valid_reg || m_ready;
    assign pop_ready = !pop_item.term || out_free;
    assign take      = pop_valid && pop_ready;
    assign allow_neg = (mode == MODE_S64) || (mode == MODE_S32);
    assign force_oct = (mode == MODE_OCT32);

    assign m_valid        = m_valid_reg;
    assign m_parsed_value = value_reg;
    assign m_status_code  = status_reg;

    // accumulator times radix plus digit, with carry-out bits for overflow
    always_comb begin
        case (phase_reg)
            PH_HEX:  scaled = {acc_reg, 4'b0000};
            PH_OCT:  scaled = {1'b0, acc_reg, 3'b000};
            default: scaled = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
        endcase
        stepped = scaled + {64'd0, pop_item.digit};
        case (phase_reg)
            PH_HEX:  dig_ok = pop_item.hex_ok;
            PH_OCT:  dig_ok = pop_item.oct_ok;
            default: dig_ok = pop_item.dec_ok;
        endcase
    end

    // final range checks at the terminator
    always_comb begin
        fin_value  = 64'd0;
        fin_status = ST_OK;
        if (err_reg != ST_OK) begin
            fin_status = err_reg;
        end else if (phase_reg == PH_INIT) begin
            fin_status = ST_NODIG;
        end else if (mode == MODE_U64) begin
            fin_value = acc_reg;
        end else if (mode == MODE_OCT32) begin
            if (acc_reg > INT_MAX_POS) begin
                fin_status = ST_BIGINT;
            end else begin
                fin_value = acc_reg;
            end
        end else if (acc_reg[63]) begin
            fin_status = ST_BIG64;
        end else if ((mode == MODE_S32) && neg_reg && (acc_reg > INT_MAX_NEG)) begin
            fin_status = ST_NEGINT;
        end else if ((mode == MODE_S32) && !neg_reg && (acc_reg > INT_MAX_POS)) begin
            fin_status = ST_BIGINT;
        end else begin
            fin_value = neg_reg ? (64'd0 - acc_reg) : acc_reg;
        end
    end

    // next state and result
    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        err_next     = err_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;

        if (take && pop_item.term) begin
            m_valid_next = 1'b1;
            value_next   = fin_value;
            status_next  = fin_status;
            phase_next   = PH_INIT;
            acc_next     = 64'd0;
            neg_next     = 1'b0;
            err_next     = ST_OK;
        end else if (take && (err_reg == ST_OK)) begin
            unique case (phase_reg)
                PH_INIT: begin
                    if (pop_item.zero) begin
                        phase_next = PH_ZERO;
                    end else if (pop_item.minus) begin
                        if (!allow_neg) begin
                            err_next = ST_NEG;
                        end else begin
                            neg_next = 1'b1;
                        end
                    end else if (!pop_item.ws) begin
                        phase_next = force_oct ? PH_OCT : PH_DEC;
                        if (force_oct ? !pop_item.oct_ok : !pop_item.dec_ok) begin
                            err_next = ST_BADFIRST;
                        end else begin
                            acc_next = {60'd0, pop_item.digit};
                        end
                    end
                end
                PH_ZERO: begin
                    if (pop_item.zero) begin
                        err_next = ST_DBLZERO;
                    end else if (pop_item.ex && !force_oct) begin
                        phase_next = PH_HEX;
                    end else begin
                        phase_next = PH_OCT;
                        if (!pop_item.oct_ok) begin
                            err_next = ST_BADOCT;
                        end else begin
                            acc_next = {60'd0, pop_item.digit};
                        end
                    end
                end
                PH_WS: begin
                    if (!pop_item.ws) begin
                        err_next = ST_TRAIL;
                    end
                end
                PH_HEX, PH_OCT, PH_DEC: begin
                    if (pop_item.ws) begin
                        phase_next = PH_WS;
                    end else if (!dig_ok) begin
                        err_next = ST_BADDIG;
                    end else if (|stepped[67:64]) begin
                        err_next = ST_OVF64;
                    end else begin
                        acc_next = stepped[63:0];
                    end
                end
                default: begin
                    err_next = ST_BADDIG;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_INIT;
            acc_reg     <= 64'd0;
            neg_reg     <= 1'b0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

endmodule

// ----- hw/rtl/string_to_integer_parser.sv -----
// top level of the streaming string to integer parser
//
//  channel   direction  ports                               transaction
//  s_        in         s_valid s_ready s_char_code         one character
//  m_        out        m_valid m_ready m_parsed_value ...  one result per string
//  cfg_      in         cfg_wr_en cfg_wr_data               parse mode write
//
// one character is taken per cycle while the queue has room; the back end parse
// state machine pops one queued character per cycle, a terminator only once the
// result register is free, and registers m_valid as it pops the terminator.
// reset clears the queue, the parse state and the mode (unsigned 64-bit).
// a stalled result holds the back end only at the next terminator; digits keep
// flowing meanwhile, and the two entry queue absorbs front side stalls.
module string_to_integer_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_parsed_value,
    output logic [3:0]  m_status_code
);
    import strint_pkg::*;

    strint_mode_t mode_reg;
    logic         push_valid;
    logic         push_ready;
    strint_item_t push_item;
    logic         pop_valid;
    logic         pop_ready;
    strint_item_t pop_item;

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_U64;
        end else if (cfg_wr_en) begin
            mode_reg <= strint_mode_t'(cfg_wr_data);
        end
    end

    strint_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    strint_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    strint_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .mode           (mode_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parsed_value (m_parsed_value),
        .m_status_code  (m_status_code)
    );

endmodule

// ----- hw/rtl/strint_checker.sv -----
// port level checks for the string to integer parser, with bind
module strint_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_parsed_value,
    input logic [3:0]  m_status_code
);
    import strint_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_parsed_value) && $stable(m_status_code))
        else $error("result changed while stalled");

    // failed parse reports zero
    a_zero_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status_code != ST_OK) |-> (m_parsed_value == 64'd0))
        else $error("nonzero value with error status");

    // status within the defined codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status_code <= ST_NEGINT))
        else $error("undefined status code");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind string_to_integer_parser strint_checker u_strint_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_parsed_value (m_parsed_value),
    .m_status_code  (m_status_code)
);

// ----- bench/tb_string_to_integer_parser.sv -----
// self-checking testbench for the streaming string to integer parser
`timescale 1ns / 100ps

module tb_string_to_integer_parser;
    import strint_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TOTAL_CHARS    = 1450;
    localparam int MAX_REPORTS    = 50;

    // one expected parse outcome per terminated string
    typedef struct packed {
        logic [63:0]    value;
        strint_status_t status;
    } parse_result_t;

    // receiver ready behaviour, picked at random for each run of the receiver
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_HOLD
    } rx_style_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [1:0]  cfg_wr_data    = 2'd0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code    = 8'd0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [63:0] m_parsed_value;
    logic [3:0]  m_status_code;

    // parser state mirrored by the predictor
    strint_mode_t   cur_mode  = MODE_U64;
    strint_phase_t  cur_phase = PH_INIT;
    logic [63:0]    cur_acc   = 64'd0;
    logic           cur_neg   = 1'b0;
    strint_status_t cur_err   = ST_OK;

    parse_result_t pending_parses[$];
    logic [7:0]    char_run[$];

    int        chars_sent  = 0;
    int        burst_left  = 0;
    int        fail_count  = 0;
    int        idle_cycles = 0;
    int        stall_left  = 0;
    rx_style_t stall_style = RX_ALWAYS;
    bit        no_gaps     = 1'b0;

    string_to_integer_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parsed_value (m_parsed_value),
        .m_status_code  (m_status_code)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic bit is_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // digit weight in the given phase, -1 when not a digit there
    function automatic int digit_value(strint_phase_t ph, logic [7:0] c);
        case (ph)
            PH_HEX: begin
                if (c >= "0" && c <= "9") return int'(c - "0");
                if (c >= "a" && c <= "f") return int'(c - "a") + 10;
                if (c >= "A" && c <= "F") return int'(c - "A") + 10;
                return -1;
            end
            PH_OCT: begin
                if (c >= "0" && c <= "7") return int'(c - "0");
                return -1;
            end
            PH_DEC: begin
                if (c >= "0" && c <= "9") return int'(c - "0");
                return -1;
            end
            default: return -1;
        endcase
    endfunction

    function automatic void clear_parse();
        cur_phase = PH_INIT;
        cur_acc   = 64'd0;
        cur_neg   = 1'b0;
        cur_err   = ST_OK;
    endfunction

    // advance the parse by one non-terminating character
    function automatic void step_parser(logic [7:0] c);
        int          d;
        bit          allow_neg;
        bit          force_oct;
        logic [4:0]  radix;
        logic [3:0]  d_bits;
        logic [67:0] wide;
        allow_neg = (cur_mode == MODE_S64) || (cur_mode == MODE_S32);
        force_oct = (cur_mode == MODE_OCT32);
        case (cur_phase)
            PH_INIT: begin
                if (c == "0") begin
                    cur_phase = PH_ZERO;
                end else if (c == "-") begin
                    if (!allow_neg) cur_err = ST_NEG;
                    else cur_neg = 1'b1;
                end else if (!is_space(c)) begin
                    if (force_oct) cur_phase = PH_OCT;
                    else cur_phase = PH_DEC;
                    d = digit_value(cur_phase, c);
                    if (d < 0) cur_err = ST_BADFIRST;
                    else cur_acc = 64'(d);
                end
            end
            PH_ZERO: begin
                if (c == "0") begin
                    cur_err = ST_DBLZERO;
                end else if (c == "x" && !force_oct) begin
                    cur_phase = PH_HEX;
                end else begin
                    cur_phase = PH_OCT;
                    d = digit_value(PH_OCT, c);
                    if (d < 0) cur_err = ST_BADOCT;
                    else cur_acc = 64'(d);
                end
            end
            PH_WS: begin
                if (!is_space(c)) cur_err = ST_TRAIL;
            end
            PH_HEX, PH_OCT, PH_DEC: begin
                if (is_space(c)) begin
                    cur_phase = PH_WS;
                end else begin
                    if (cur_phase == PH_HEX) radix = 5'd16;
                    else if (cur_phase == PH_OCT) radix = 5'd8;
                    else radix = 5'd10;
                    d = digit_value(cur_phase, c);
                    if (d < 0) begin
                        cur_err = ST_BADDIG;
                    end else begin
                        // exact 64-bit overflow test in a wider sum
                        d_bits = 4'(d);
                        wide   = cur_acc;
                        wide   = wide * radix + d_bits;
                        if (wide[67:64] != 4'd0) cur_err = ST_OVF64;
                        else cur_acc = wide[63:0];
                    end
                end
            end
            default: cur_err = ST_BADDIG;
        endcase
    endfunction

    // outcome of the string when its terminator arrives
    function automatic parse_result_t finish_parse();
        parse_result_t r;
        r.value  = 64'd0;
        r.status = ST_OK;
        if (cur_err != ST_OK) begin
            r.status = cur_err;
        end else if (cur_phase == PH_INIT) begin
            r.status = ST_NODIG;
        end else if (cur_mode == MODE_U64) begin
            r.value = cur_acc;
        end else if (cur_mode == MODE_OCT32) begin
            if (cur_acc > INT_MAX_POS) r.status = ST_BIGINT;
            else r.value = cur_acc;
        end else if (cur_acc[63]) begin
            // magnitude 2^63 is refused even when negative
            r.status = ST_BIG64;
        end else if (cur_mode == MODE_S32 && cur_neg && cur_acc > INT_MAX_NEG) begin
            r.status = ST_NEGINT;
        end else if (cur_mode == MODE_S32 && !cur_neg && cur_acc > INT_MAX_POS) begin
            r.status = ST_BIGINT;
        end else begin
            r.value = cur_neg ? (64'd0 - cur_acc) : cur_acc;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one character transaction, with bursts and random gaps before it
    task automatic send_char(logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_char_code <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        if (c == 8'd0) begin
            pending_parses.push_back(finish_parse());
            clear_parse();
        end else if (cur_err == ST_OK) begin
            step_parser(c);
        end
    endtask

    task automatic send_run();
        foreach (char_run[i]) send_char(char_run[i]);
        send_char(8'd0);
    endtask

    task automatic send_text(string s);
        char_run = {};
        for (int i = 0; i < s.len(); i++) char_run.push_back(s[i]);
        send_run();
    endtask

    // hold the sender until every outstanding string has been answered
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_parses.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic set_mode(strint_mode_t m);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_mode = m;
    endtask

    // ------------------------------------------------------------------
    // receiver, checker and watchdog
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_style = rx_style_t'($urandom_range(0, 3));
            stall_left  = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_style)
            RX_ALWAYS: m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= (stall_left < 4);
        endcase
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (fail_count < MAX_REPORTS)
            $display("mismatch at %0t: %s got 0x%h want 0x%h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin : result_check
        parse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_parses.size() == 0) begin
                report_mismatch("result with no string pending", m_parsed_value, 64'd0);
            end else begin
                want = pending_parses.pop_front();
                if (m_parsed_value !== want.value)
                    report_mismatch("parsed value", m_parsed_value, want.value);
                if (m_status_code !== want.status)
                    report_mismatch("status code", 64'(m_status_code), 64'(want.status));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[string_to_integer_parser] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // random string builder
    // ------------------------------------------------------------------

    function automatic logic [7:0] random_space();
        int pick;
        pick = $urandom_range(8, 13);
        return (pick == 8) ? 8'd32 : 8'(pick);
    endfunction

    // values spread over the small range, random widths and the limits
    function automatic logic [63:0] pick_value();
        logic [63:0] anchor;
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(0, 999));
            1: return {$urandom, $urandom} >> $urandom_range(0, 63);
            default: begin
                case ($urandom_range(0, 6))
                    0:       anchor = 64'h0000_0000_7FFF_FFFF;
                    1:       anchor = 64'h0000_0000_8000_0000;
                    2:       anchor = 64'h0000_0000_FFFF_FFFF;
                    3:       anchor = 64'h7FFF_FFFF_FFFF_FFFF;
                    4:       anchor = 64'h8000_0000_0000_0000;
                    5:       anchor = 64'hFFFF_FFFF_FFFF_FFFF;
                    default: anchor = 64'h1999_9999_9999_9999;
                endcase
                return anchor + 64'($urandom_range(0, 6)) - 64'd3;
            end
        endcase
    endfunction

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) char_run.push_back(s[i]);
    endtask

    // mostly well-formed numbers with spaces and signs, some noise and damage
    task automatic build_random_run();
        int          kind;
        string       digits;
        logic [7:0]  c;
        logic [63:0] v;
        char_run = {};
        repeat ($urandom_range(0, 2)) char_run.push_back(random_space());
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                char_run.push_back("-");
                if ($urandom_range(0, 2) == 0) char_run.push_back(random_space());
            end
        end
        kind = $urandom_range(0, 9);
        v    = pick_value();
        case (kind)
            0: repeat ($urandom_range(1, 6)) char_run.push_back(8'($urandom_range(1, 255)));
            1: begin
                char_run.push_back("0");
                if ($urandom_range(0, 1) != 0) char_run.push_back("x");
            end
            2, 3: push_text($sformatf("%0d", v));
            4, 5: begin
                push_text("0x");
                digits = $sformatf("%0h", v);
                for (int i = 0; i < digits.len(); i++) begin
                    c = digits[i];
                    if (c >= "a" && c <= "f" && $urandom_range(0, 1) != 0) c = c - 8'd32;
                    char_run.push_back(c);
                end
            end
            6: push_text({"0", $sformatf("%0o", v)});
            7: push_text($sformatf("%0o", v));
            8: repeat ($urandom_range(1, 25)) char_run.push_back(8'($urandom_range(48, 57)));
            default: ;
        endcase
        // one digit more pushes limit values over the edge
        if (kind >= 2 && kind <= 8 && $urandom_range(0, 5) == 0)
            char_run.push_back(8'($urandom_range(48, 57)));
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) char_run.push_back(random_space());
        if (char_run.size() != 0 && $urandom_range(0, 7) == 0)
            char_run[$urandom_range(0, char_run.size() - 1)] = 8'($urandom_range(1, 255));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // radix prefixes, spacing, lone zero and the early error codes
    task automatic test_radix_forms();
        set_mode(MODE_U64);
        send_text("0");
        send_text("0x");
        send_text("");
        send_text("00");
        send_text("0 ");
        send_text("0x1F");
        send_text("0777");
        send_text("08");
        send_text("12a");
        send_text("12 3");
        send_text("a");
        send_text("-5");
        char_run = {8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32, "7", 8'd11, 8'd12};
        send_run();
        char_run = {8'd9, 8'd32};
        send_run();
        char_run = {8'hFF};
        send_run();
        char_run = {"1", 8'h80, 8'h7F};
        send_run();
    endtask

    // exact 64-bit overflow in every radix
    task automatic test_u64_limits();
        send_text("18446744073709551615");
        send_text("18446744073709551616");
        send_text("0xFFFFFFFFffffffff");
        send_text("0x10000000000000000");
        send_text("01777777777777777777777");
        send_text("02000000000000000000000");
    endtask

    // repeated minus, minus zero and the most negative magnitude
    task automatic test_signed64();
        set_mode(MODE_S64);
        send_text("-9223372036854775807");
        send_text("9223372036854775808");
        send_text("-9223372036854775808");
        send_text(" - -17");
        send_text("-");
        send_text("-0");
        send_text("-0x1f");
    endtask

    // forced octal refuses hex and decimal digits
    task automatic test_forced_octal();
        set_mode(MODE_OCT32);
        send_text("017");
        send_text("0x1");
        send_text("8");
        send_text("17777777777");
        send_text("20000000000");
        send_text("-1");
    endtask

    // signed 32-bit range ends
    task automatic test_int32();
        set_mode(MODE_S32);
        send_text("2147483647");
        send_text("2147483648");
        send_text("-2147483648");
        send_text("-2147483649");
        send_text("--12");
    endtask

    // random strings in phases, each with its own mode and idling
    task automatic test_random_strings();
        int stop_at;
        // the whole run, directed strings included, stops near the character budget
        stop_at = TOTAL_CHARS;
        while (chars_sent < stop_at) begin
            set_mode(strint_mode_t'($urandom_range(0, 3)));
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(5, 20)) begin
                if (chars_sent < stop_at) begin
                    build_random_run();
                    send_run();
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_radix_forms();
        test_u64_limits();
        test_signed64();
        test_forced_octal();
        test_int32();
        test_random_strings();
        wait_for_results();
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[string_to_integer_parser] OK");
        end else begin
            $display("[string_to_integer_parser] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/strint_pkg.sv
hw/rtl/strint_front.sv
hw/rtl/strint_queue.sv
hw/rtl/strint_back.sv
hw/rtl/string_to_integer_parser.sv
hw/rtl/strint_checker.sv
bench/tb_string_to_integer_parser.sv
